[sv/bb3_pkg.sv]
package bb3_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // one entry of the line store: the row two above and the row one above
  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
  } line_pair_t;

  // neighbors that fall outside the frame
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } border_t;

  typedef struct packed {
    rgb_t color;
    logic frame_end;
  } result_t;

  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = 2;
  localparam int OUT_CNT_W  = 3;

  localparam int SUM_W = 12;
  // floor(x / 9) == (x * 3641) >> 15 for every x below 32768
  localparam logic [11:0] RECIP9 = 12'd3641;

  function automatic logic [7:0] div9(input logic [SUM_W-1:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'(RECIP9);
    return prod[22:15];
  endfunction

endpackage

[sv/bb3_line_store.sv]
module bb3_line_store #(
  parameter int DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  bb3_pkg::line_pair_t       wr_data_i,
  output bb3_pkg::line_pair_t       rd_data_o
);

  bb3_pkg::line_pair_t mem [DEPTH];
  bb3_pkg::line_pair_t rd_data_q;
  bb3_pkg::line_pair_t fwd_data_q;
  logic                fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q  <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // a read of the entry written in the same cycle takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_data_q;

endmodule

[sv/bb3_out_fifo.sv]
module bb3_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  bb3_pkg::result_t               push_data_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output bb3_pkg::result_t               out_data_o,
  output logic [bb3_pkg::OUT_CNT_W-1:0]  count_o
);

  bb3_pkg::result_t                   mem [bb3_pkg::OUT_DEPTH];
  logic [bb3_pkg::OUT_PTR_W-1:0]      wr_ptr_q;
  logic [bb3_pkg::OUT_PTR_W-1:0]      rd_ptr_q;
  logic [bb3_pkg::OUT_CNT_W-1:0]      count_q;
  logic                               pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem[rd_ptr_q];
  assign count_o     = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + bb3_pkg::OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + bb3_pkg::OUT_PTR_W'(1);
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + bb3_pkg::OUT_CNT_W'(1);
        2'b01:   count_q <= count_q - bb3_pkg::OUT_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[sv/box_blur_3x3_rgb_unit.sv]
// 3x3 box blur over a raster RGB stream, one item per clock sustained while the output
// is not stalled. A result passes stage 1 and stage 2 into the output queue after the
// transfer of the item that completes its neighborhood; in items the output trails the
// input by one row plus one pixel, and drain items push out the tail of the frame.
// Reset: stream position, window and output queue clear; width 640, height 480;
// the line stores are not cleared and need no clearing pass.
module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [7:0]                      in_red_i,
  input  logic [7:0]                      in_green_i,
  input  logic [7:0]                      in_blue_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_red_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_blue_o,
  output logic                            frame_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bb3_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  // configuration
  logic [bb3_pkg::CFG_W-1:0] width_q, height_q;
  logic                      cfg_wr, cfg_hit;
  logic [WW-1:0]             w_c;
  logic [HW-1:0]             h_c;

  // stream position
  logic [XW-1:0] col_q, col_e, col_n;
  logic [RW-1:0] row_q, row_e, row_n;
  logic [XW-1:0] ox_q, ox_e, ox_n;
  logic [YW-1:0] oy_q, oy_e, oy_n;
  logic          restart, filling, take, ignore, go, emit, wrap, ox_last, oy_last, fend;
  logic [31:0]   col_inc;
  bb3_pkg::rgb_t    pixel;
  bb3_pkg::border_t border;

  // stage 1: line store read returns, window shifts
  logic              s1_valid_q, s1_emit_q, s1_fend_q;
  logic [XW-1:0]     s1_col_q;
  bb3_pkg::rgb_t     s1_pixel_q;
  bb3_pkg::border_t  s1_border_q;
  bb3_pkg::line_pair_t ls_rd, ls_wr;

  // stage 2: sum and divide into the output queue
  logic              s2_valid_q, s2_fend_q;
  bb3_pkg::border_t  s2_border_q;
  bb3_pkg::rgb_t     window_q [9];
  logic [bb3_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
  bb3_pkg::result_t  result;
  bb3_pkg::result_t  out_data;
  logic [bb3_pkg::OUT_CNT_W-1:0] fifo_count;
  logic [3:0]        credits_used;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_wr && ((cfg_index_i == bb3_pkg::CFG_FRAME_WIDTH) ||
                                  (cfg_index_i == bb3_pkg::CFG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3_pkg::FRAME_WIDTH_RST;
      height_q <= bb3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (cfg_index_i == bb3_pkg::CFG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == bb3_pkg::CFG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (width_q == '0) begin
      w_c = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(width_q);
    end
    if (height_q == '0) begin
      h_c = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(height_q);
    end
  end

  // credits: every item in flight may still land in the output queue
  assign credits_used = 4'(fifo_count) + 4'(s1_valid_q) + 4'(s2_valid_q);
  assign in_stall_o   = (credits_used >= 4'(bb3_pkg::OUT_DEPTH));

  always_comb begin
    restart = (32'(col_q) >= 32'(w_c)) || (32'(row_q) > (32'(h_c) + 32'd1));
    col_e   = restart ? '0 : col_q;
    row_e   = restart ? '0 : row_q;
    ox_e    = restart ? '0 : ox_q;
    oy_e    = restart ? '0 : oy_q;

    filling = (32'(row_e) < 32'(h_c));
    take    = in_valid_i && !in_stall_o;
    ignore  = cmd_i && filling;
    go      = take && !ignore;

    if (!cmd_i && filling) begin
      pixel = '{red: in_red_i, green: in_green_i, blue: in_blue_i};
    end else begin
      pixel = '0;
    end

    emit    = (row_e >= RW'(2)) || ((row_e == RW'(1)) && (col_e != '0));
    col_inc = 32'(col_e) + 32'd1;
    wrap    = (col_inc >= 32'(w_c));
    col_n   = wrap ? '0 : XW'(col_inc);
    row_n   = wrap ? row_e + RW'(1) : row_e;

    ox_last = ((32'(ox_e) + 32'd1) >= 32'(w_c));
    oy_last = ((32'(oy_e) + 32'd1) >= 32'(h_c));
    fend    = ox_last && oy_last;
    border  = '{left: (ox_e == '0), right: ox_last, top: (oy_e == '0), bottom: oy_last};
    ox_n    = ox_last ? '0 : ox_e + XW'(1);
    oy_n    = ox_last ? YW'(32'(oy_e) + 32'd1) : oy_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
    end else if (take) begin
      if (ignore) begin
        col_q <= col_e;
        row_q <= row_e;
        ox_q  <= ox_e;
        oy_q  <= oy_e;
      end else if (emit && fend) begin
        col_q <= '0;
        row_q <= '0;
        ox_q  <= '0;
        oy_q  <= '0;
      end else begin
        col_q <= col_n;
        row_q <= row_n;
        ox_q  <= emit ? ox_n : ox_e;
        oy_q  <= emit ? oy_n : oy_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= go;
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_col_q    <= col_e;
      s1_pixel_q  <= pixel;
      s1_emit_q   <= emit;
      s1_fend_q   <= fend;
      s1_border_q <= border;
    end
    if (s1_valid_q) begin
      s2_fend_q   <= s1_fend_q;
      s2_border_q <= s1_border_q;
    end
  end

  // each entry moves down one row: middle becomes upper, new pixel becomes middle
  assign ls_wr = '{upper: ls_rd.middle, middle: s1_pixel_q};

  bb3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (go),
    .rd_addr_i (col_e),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (ls_wr),
    .rd_data_o (ls_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        window_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        window_q[r*3]     <= window_q[r*3 + 1];
        window_q[r*3 + 1] <= window_q[r*3 + 2];
      end
      window_q[2] <= ls_rd.upper;
      window_q[5] <= ls_rd.middle;
      window_q[8] <= s1_pixel_q;
    end
  end

  // drop neighbors outside the frame; divisor stays nine
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((c == 0) && s2_border_q.left) && !((c == 2) && s2_border_q.right) &&
            !((r == 0) && s2_border_q.top) && !((r == 2) && s2_border_q.bottom)) begin
          sum_r = sum_r + bb3_pkg::SUM_W'(window_q[r*3 + c].red);
          sum_g = sum_g + bb3_pkg::SUM_W'(window_q[r*3 + c].green);
          sum_b = sum_b + bb3_pkg::SUM_W'(window_q[r*3 + c].blue);
        end
      end
    end
    result.color.red   = bb3_pkg::div9(sum_r);
    result.color.green = bb3_pkg::div9(sum_g);
    result.color.blue  = bb3_pkg::div9(sum_b);
    result.frame_end   = s2_fend_q;
  end

  bb3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .count_o     (fifo_count)
  );

  assign out_red_o   = out_data.color.red;
  assign out_green_o = out_data.color.green;
  assign out_blue_o  = out_data.color.blue;
  assign frame_end_o = out_data.frame_end;

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credits_used <= 4'(bb3_pkg::OUT_DEPTH))
    else $error("output queue credits exceeded");

  a_drain_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cmd_i && filling) |=> !s1_valid_q)
    else $error("drain during fill entered the pipeline");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> $past(s1_valid_q && s1_emit_q))
    else $error("result without an emitting item");

endmodule
